/* rtl/assert_macros.svh */
// Assertion macros for the checker file.
// Needs nothing else; each macro takes a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/mbrs_pkg.sv */
// Package for the Modbus RTU read slave: types, constants and the CRC-16 step.
// No dependencies; used by every module of the block but the checker.
package mbrs_pkg;

    localparam int          NUM_REGS_DEF   = 32;
    localparam int          MAX_WORDS      = 32;

    localparam logic [7:0]  ADDR_RESET     = 8'd101;
    localparam logic [15:0] HOST_RESET     = 16'd100;
    localparam logic [7:0]  CHAN_RESET     = 8'd15;

    localparam logic [7:0]  FUNC_READ      = 8'd3;
    localparam logic [7:0]  BYTE_COUNT     = 8'd2;
    localparam logic [7:0]  QTY_ONE        = 8'd1;
    localparam logic [7:0]  WORD_LIMIT     = 8'd32;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    localparam logic [2:0]  FRAME_LAST_POS = 3'd7;
    localparam logic [2:0]  CRC_SPAN_LAST  = 3'd5;

    localparam logic [4:0]  WORD_SLAVE     = 5'd0;
    localparam logic [4:0]  WORD_HOST      = 5'd7;
    localparam logic [4:0]  WORD_CHAN      = 5'd8;

    typedef enum logic [1:0] {
        CFG_SLAVE = 2'd0,
        CFG_HOST  = 2'd1,
        CFG_CHAN  = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        RP_HOST_HI = 4'd0,
        RP_HOST_LO = 4'd1,
        RP_CHAN    = 4'd2,
        RP_SLAVE   = 4'd3,
        RP_FUNC    = 4'd4,
        RP_COUNT   = 4'd5,
        RP_WORD_HI = 4'd6,
        RP_WORD_LO = 4'd7,
        RP_CRC_LO  = 4'd8,
        RP_CRC_HI  = 4'd9
    } reply_pos_t;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [15:0] host_address;
        logic [7:0]  radio_channel;
    } cfg_regs_t;

    typedef struct packed {
        logic       start;
        logic       at_last;
        logic [4:0] rd_index;
    } frame_status_t;

    // One byte of the reflected Modbus CRC-16.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/modbus_rtu_read_slave.sv */
// Modbus RTU read-holding-register slave. A received byte or a local register word update is
// taken while s_tready is high, so items can arrive back to back. The frame collector checks
// an 8-byte request with a running CRC as its bytes arrive; a valid read request loads the
// reply sequencer, whose first byte is offered in the cycle after the final request byte. It
// sends ten bytes, one per cycle while m_tready is high. Once seven bytes of a following
// request are in while a reply is still being sent (up to and including the cycle of its
// final transfer), s_tready is low and no item of either kind is taken until the reply is out.
// Configuration writes are taken every cycle (cfg_ready is tied high).
// Depends on mbrs_pkg, mbrs_frame, mbrs_regs and mbrs_reply.
module modbus_rtu_read_slave #(
    parameter int NUM_REGS = mbrs_pkg::NUM_REGS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rx_data[7:0], reg_index[12:8], reg_value[28:13], zero
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tx_data[7:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    mbrs_pkg::frame_status_t frame_st;
    mbrs_pkg::cfg_regs_t     cfg;
    logic                    s_fire;
    logic                    byte_fire;
    logic                    wr_fire;
    logic [15:0]             rd_word;

    assign cfg_ready = 1'b1;
    assign s_tready  = !(m_tvalid && frame_st.at_last);
    assign s_fire    = s_tvalid && s_tready;
    assign byte_fire = s_fire && !s_tuser;
    assign wr_fire   = s_fire && s_tuser;

    mbrs_frame u_frame (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_fire     (byte_fire),
        .rx_data       (s_tdata[7:0]),
        .slave_address (cfg.slave_address),
        .status        (frame_st)
    );

    mbrs_regs #(
        .NUM_REGS (NUM_REGS)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr_fire   (wr_fire),
        .wr_index  (s_tdata[12:8]),
        .wr_value  (s_tdata[28:13]),
        .rd_index  (frame_st.rd_index),
        .rd_word   (rd_word),
        .cfg       (cfg)
    );

    mbrs_reply u_reply (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (frame_st.start),
        .word     (rd_word),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/mbrs_frame.sv */
// Request frame collector: byte position, running CRC and frame checks.
// Depends on mbrs_pkg.
module mbrs_frame (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     byte_fire,
    input  logic [7:0]               rx_data,
    input  logic [7:0]               slave_address,
    output mbrs_pkg::frame_status_t  status
);

    logic [2:0]  pos_reg,  pos_next;
    logic [15:0] crc_reg,  crc_next;
    logic [7:0]  frame_reg [0:6];

    logic [7:0]  byte0;
    logic [15:0] crc_base;
    logic [15:0] crc_upd;
    logic        frame_ok;

    always_comb begin
        byte0    = (pos_reg == 3'd0) ? rx_data : frame_reg[0];
        crc_base = (pos_reg == 3'd0) ? mbrs_pkg::CRC_INIT : crc_reg;
        crc_upd  = mbrs_pkg::crc16_byte(crc_base, rx_data);

        frame_ok = (frame_reg[2] == 8'h00) &&
                   (frame_reg[3] <  mbrs_pkg::WORD_LIMIT) &&
                   (frame_reg[4] == 8'h00) &&
                   (frame_reg[5] == mbrs_pkg::QTY_ONE) &&
                   (frame_reg[6] == crc_reg[7:0]) &&
                   (rx_data      == crc_reg[15:8]) &&
                   (frame_reg[1] == mbrs_pkg::FUNC_READ);

        pos_next = pos_reg;
        crc_next = crc_reg;
        if (byte_fire) begin
            if (pos_reg == mbrs_pkg::FRAME_LAST_POS) begin
                pos_next = 3'd0;
            end else begin
                pos_next = (byte0 == slave_address) ? pos_reg + 3'd1 : 3'd0;
            end
            if (pos_reg <= mbrs_pkg::CRC_SPAN_LAST) begin
                crc_next = crc_upd;
            end
        end

        status.at_last  = (pos_reg == mbrs_pkg::FRAME_LAST_POS);
        status.start    = byte_fire && status.at_last && frame_ok;
        status.rd_index = frame_reg[3][4:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 3'd0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
        if (byte_fire && pos_reg != mbrs_pkg::FRAME_LAST_POS) begin
            frame_reg[pos_reg] <= rx_data;
        end
    end

endmodule

/* rtl/mbrs_regs.sv */
// Configuration registers, general register words and the word read mux.
// Depends on mbrs_pkg.
module mbrs_regs #(
    parameter int NUM_REGS = mbrs_pkg::NUM_REGS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_fire,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 wr_fire,
    input  logic [4:0]           wr_index,
    input  logic [15:0]          wr_value,
    input  logic [4:0]           rd_index,
    output logic [15:0]          rd_word,
    output mbrs_pkg::cfg_regs_t  cfg
);

    localparam int STORE_DEPTH = (NUM_REGS < mbrs_pkg::MAX_WORDS) ?
                                 NUM_REGS : mbrs_pkg::MAX_WORDS;

    mbrs_pkg::cfg_regs_t cfg_reg;
    logic [15:0]         store_reg [0:STORE_DEPTH-1];
    logic                wr_ok;

    assign cfg   = cfg_reg;
    assign wr_ok = wr_fire && (wr_index != mbrs_pkg::WORD_SLAVE) &&
                   (wr_index != mbrs_pkg::WORD_HOST) && (wr_index != mbrs_pkg::WORD_CHAN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slave_address <= mbrs_pkg::ADDR_RESET;
            cfg_reg.host_address  <= mbrs_pkg::HOST_RESET;
            cfg_reg.radio_channel <= mbrs_pkg::CHAN_RESET;
        end else if (cfg_fire) begin
            unique case (mbrs_pkg::cfg_index_t'(cfg_index))
                mbrs_pkg::CFG_SLAVE: cfg_reg.slave_address <= cfg_data[7:0];
                mbrs_pkg::CFG_HOST:  cfg_reg.host_address  <= cfg_data;
                mbrs_pkg::CFG_CHAN:  cfg_reg.radio_channel <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                store_reg[i] <= 16'h0000;
            end
        end else begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                if (wr_ok && wr_index == 5'(i)) begin
                    store_reg[i] <= wr_value;
                end
            end
        end
    end

    always_comb begin
        rd_word = 16'h0000;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (rd_index == 5'(i)) begin
                rd_word = store_reg[i];
            end
        end
        priority if (rd_index == mbrs_pkg::WORD_SLAVE) begin
            rd_word = {8'h00, cfg_reg.slave_address};
        end else if (rd_index == mbrs_pkg::WORD_HOST) begin
            rd_word = cfg_reg.host_address;
        end else if (rd_index == mbrs_pkg::WORD_CHAN) begin
            rd_word = {8'h00, cfg_reg.radio_channel};
        end else begin
            rd_word = rd_word;
        end
    end

endmodule

/* rtl/mbrs_reply.sv */
// Reply sequencer: emits the ten reply bytes and builds the CRC of bytes slave to word low, byte by byte.
// Depends on mbrs_pkg.
module mbrs_reply (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [15:0]          word,
    input  mbrs_pkg::cfg_regs_t  cfg,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);

    logic                 busy_reg, busy_next;
    mbrs_pkg::reply_pos_t pos_reg,  pos_next;
    logic [15:0]          word_reg, word_next;
    logic [15:0]          crc_reg,  crc_next;

    logic [7:0]  tx_byte;
    logic [15:0] crc_upd;
    logic        xfer;

    always_comb begin
        unique case (pos_reg)
            mbrs_pkg::RP_HOST_HI: tx_byte = cfg.host_address[15:8];
            mbrs_pkg::RP_HOST_LO: tx_byte = cfg.host_address[7:0];
            mbrs_pkg::RP_CHAN:    tx_byte = cfg.radio_channel;
            mbrs_pkg::RP_SLAVE:   tx_byte = cfg.slave_address;
            mbrs_pkg::RP_FUNC:    tx_byte = mbrs_pkg::FUNC_READ;
            mbrs_pkg::RP_COUNT:   tx_byte = mbrs_pkg::BYTE_COUNT;
            mbrs_pkg::RP_WORD_HI: tx_byte = word_reg[15:8];
            mbrs_pkg::RP_WORD_LO: tx_byte = word_reg[7:0];
            mbrs_pkg::RP_CRC_LO:  tx_byte = crc_reg[7:0];
            mbrs_pkg::RP_CRC_HI:  tx_byte = crc_reg[15:8];
            default:              tx_byte = 8'h00;
        endcase

        xfer    = busy_reg && m_tready;
        crc_upd = mbrs_pkg::crc16_byte((pos_reg == mbrs_pkg::RP_SLAVE) ?
                                       mbrs_pkg::CRC_INIT : crc_reg, tx_byte);

        crc_next = crc_reg;
        if (xfer && pos_reg >= mbrs_pkg::RP_SLAVE && pos_reg <= mbrs_pkg::RP_WORD_LO) begin
            crc_next = crc_upd;
        end

        busy_next = busy_reg;
        pos_next  = pos_reg;
        word_next = word_reg;
        if (start) begin
            busy_next = 1'b1;
            pos_next  = mbrs_pkg::RP_HOST_HI;
            word_next = word;
        end else if (xfer) begin
            if (pos_reg == mbrs_pkg::RP_CRC_HI) begin
                busy_next = 1'b0;
                pos_next  = mbrs_pkg::RP_HOST_HI;
            end else begin
                pos_next  = mbrs_pkg::reply_pos_t'(pos_reg + 4'd1);
            end
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = tx_byte;
    assign m_tlast  = (pos_reg == mbrs_pkg::RP_CRC_HI);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= mbrs_pkg::RP_HOST_HI;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        crc_reg  <= crc_next;
    end

endmodule

/* rtl/mbrs_checker.sv */
// Port-level checker for modbus_rtu_read_slave, attached by the bind below.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mbrs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tlast
);

    `ASSERT_NEXT(a_m_valid_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_idle_after_last, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid)
    `ASSERT_IMPLY(a_reply_opens_not_last, aclk, aresetn, $rose(m_tvalid), !m_tlast)
    `ASSERT_IMPLY(a_reply_after_input, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready))

endmodule

bind modbus_rtu_read_slave mbrs_checker u_mbrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);
